[rtl/core/lqpm_pkg.sv]
// Package of the linked queue pool manager.
// Holds the opcodes, the datapath command set and the status bundle.
// Used by lqpm_ctrl, lqpm_dp and the top level; depends on nothing.
package lqpm_pkg;

  localparam logic [3:0] OP_ALLOC   = 4'd0;
  localparam logic [3:0] OP_FREE    = 4'd1;
  localparam logic [3:0] OP_ENQUEUE = 4'd2;
  localparam logic [3:0] OP_DEQUEUE = 4'd3;
  localparam logic [3:0] OP_REMOVE  = 4'd4;
  localparam logic [3:0] OP_PEEK    = 4'd5;
  localparam logic [3:0] OP_ADD     = 4'd6;
  localparam logic [3:0] OP_RFC     = 4'd7;
  localparam logic [3:0] OP_DETACH  = 4'd8;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_CLEAR,
    CMD_CAPTURE,
    CMD_LD_TAIL,
    CMD_RD_NXT_T,
    CMD_TAKE_H,
    CMD_TAKE_N,
    CMD_TAKE_LINK,
    CMD_TAKE_CLR,
    CMD_INS_FIRST,
    CMD_INS_P,
    CMD_INS_T,
    CMD_PEEK,
    CMD_WALK_RD,
    CMD_WALK_ADV,
    CMD_RM_RD,
    CMD_RM_LINK,
    CMD_RM_CLR,
    CMD_RD_FCH_PAR,
    CMD_CL_FCH,
    CMD_ADD_START,
    CMD_SIB_RD,
    CMD_ADD_STEP,
    CMD_RFC_TAKE,
    CMD_RFC_UNLINK,
    CMD_RD_PARENT,
    CMD_DT_UP,
    CMD_DT_FCH,
    CMD_DT_HEAD,
    CMD_DT_STEP,
    CMD_DT_CLR,
    CMD_OUT
  } lqpm_cmd_e;

  typedef struct packed {
    logic [3:0] op;
    logic       bad;
    logic       p_none;
    logic       par_none;
    logic       t_none;
    logic       tsrc_none;
    logic       cnt_full;
    logic       w_eq_p;
    logic       s_none;
    logic       nxt_rd_end;
    logic       fch_rd_none;
    logic       fch_rd_eq_p;
    logic       sib_rd_none;
    logic       sib_rd_eq_p;
    logic       par_rd_none;
    logic       clr_done;
  } lqpm_status_t;

endpackage

[rtl/core/lqpm_ctrl.sv]
// Controller of the linked queue pool manager: sequences datapath commands.
// Depends on lqpm_pkg.
module lqpm_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  lqpm_pkg::lqpm_status_t status_i,
  output lqpm_pkg::lqpm_cmd_e    cmd_o
);
  import lqpm_pkg::*;

  typedef enum logic [5:0] {
    ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_LD_TAIL,
    ST_TK_RD, ST_TK_H, ST_TK_N, ST_TK_LINK, ST_TK_CLR,
    ST_INS_FIRST, ST_INS_RD, ST_INS_H, ST_INS_P, ST_INS_T,
    ST_PK_RD, ST_PK,
    ST_RM_W, ST_RM_WRD, ST_RM_WADV, ST_RM_RD, ST_RM_LINK, ST_RM_CLR,
    ST_FCH_RD, ST_CL_FCH, ST_ADD_START, ST_ADD_W, ST_ADD_SRD, ST_ADD_STEP,
    ST_RFC_TAKE, ST_RFC_SRD, ST_RFC_UNLINK,
    ST_PAR_RD, ST_DT_UP, ST_DT_FCH, ST_DT_HEAD, ST_DT_W, ST_DT_SRD,
    ST_DT_STEP, ST_DT_CLR,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_load;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_load    = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    case (state_q)
      ST_CLEAR:      cmd_o = CMD_CLEAR;
      ST_IDLE:       cmd_o = in_valid_i ? CMD_CAPTURE : CMD_NOP;
      ST_LD_TAIL:    cmd_o = CMD_LD_TAIL;
      ST_TK_RD:      cmd_o = CMD_RD_NXT_T;
      ST_TK_H:       cmd_o = CMD_TAKE_H;
      ST_TK_N:       cmd_o = CMD_TAKE_N;
      ST_TK_LINK:    cmd_o = CMD_TAKE_LINK;
      ST_TK_CLR:     cmd_o = CMD_TAKE_CLR;
      ST_INS_FIRST:  cmd_o = CMD_INS_FIRST;
      ST_INS_RD:     cmd_o = CMD_RD_NXT_T;
      ST_INS_H:      cmd_o = CMD_TAKE_H;
      ST_INS_P:      cmd_o = CMD_INS_P;
      ST_INS_T:      cmd_o = CMD_INS_T;
      ST_PK_RD:      cmd_o = CMD_RD_NXT_T;
      ST_PK:         cmd_o = CMD_PEEK;
      ST_RM_WRD:     cmd_o = CMD_WALK_RD;
      ST_RM_WADV:    cmd_o = CMD_WALK_ADV;
      ST_RM_RD:      cmd_o = CMD_RM_RD;
      ST_RM_LINK:    cmd_o = CMD_RM_LINK;
      ST_RM_CLR:     cmd_o = CMD_RM_CLR;
      ST_FCH_RD:     cmd_o = CMD_RD_FCH_PAR;
      ST_CL_FCH:     cmd_o = CMD_CL_FCH;
      ST_ADD_START:  cmd_o = CMD_ADD_START;
      ST_ADD_SRD:    cmd_o = CMD_SIB_RD;
      ST_ADD_STEP:   cmd_o = CMD_ADD_STEP;
      ST_RFC_TAKE:   cmd_o = CMD_RFC_TAKE;
      ST_RFC_SRD:    cmd_o = CMD_SIB_RD;
      ST_RFC_UNLINK: cmd_o = CMD_RFC_UNLINK;
      ST_PAR_RD:     cmd_o = CMD_RD_PARENT;
      ST_DT_UP:      cmd_o = CMD_DT_UP;
      ST_DT_FCH:     cmd_o = CMD_DT_FCH;
      ST_DT_HEAD:    cmd_o = CMD_DT_HEAD;
      ST_DT_SRD:     cmd_o = CMD_SIB_RD;
      ST_DT_STEP:    cmd_o = CMD_DT_STEP;
      ST_DT_CLR:     cmd_o = CMD_DT_CLR;
      ST_DONE:       cmd_o = out_load ? CMD_OUT : CMD_NOP;
      default:       cmd_o = CMD_NOP;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:     if (status_i.clr_done) state_d = ST_IDLE;
      ST_IDLE:      if (in_valid_i) state_d = ST_DISPATCH;
      ST_DISPATCH: begin
        if (status_i.bad) begin
          state_d = ST_DONE;
        end else if (status_i.op <= OP_PEEK) begin
          state_d = ST_LD_TAIL;
        end else if (status_i.op == OP_DETACH) begin
          state_d = ST_PAR_RD;
        end else begin
          state_d = status_i.par_none ? ST_DONE : ST_FCH_RD;
        end
      end
      ST_LD_TAIL: begin
        case (status_i.op)
          OP_ALLOC, OP_DEQUEUE: state_d = status_i.tsrc_none ? ST_DONE : ST_TK_RD;
          OP_FREE, OP_ENQUEUE: begin
            if (status_i.p_none) state_d = ST_DONE;
            else if (status_i.tsrc_none) state_d = ST_INS_FIRST;
            else state_d = ST_INS_RD;
          end
          OP_REMOVE: state_d = ST_RM_W;
          OP_PEEK:   state_d = ST_PK_RD;
          default:   state_d = ST_DONE;
        endcase
      end
      ST_TK_RD:     state_d = ST_TK_H;
      ST_TK_H:      state_d = ST_TK_N;
      ST_TK_N:      state_d = ST_TK_LINK;
      ST_TK_LINK:   state_d = ST_TK_CLR;
      ST_TK_CLR:    state_d = ST_DONE;
      ST_INS_FIRST: state_d = ST_DONE;
      ST_INS_RD:    state_d = ST_INS_H;
      ST_INS_H:     state_d = ST_INS_P;
      ST_INS_P:     state_d = ST_INS_T;
      ST_INS_T:     state_d = ST_DONE;
      ST_PK_RD:     state_d = ST_PK;
      ST_PK:        state_d = ST_DONE;
      ST_RM_W: begin
        if (status_i.t_none || status_i.p_none || status_i.cnt_full) state_d = ST_DONE;
        else if (status_i.w_eq_p) state_d = ST_RM_RD;
        else state_d = ST_RM_WRD;
      end
      ST_RM_WRD:    state_d = ST_RM_WADV;
      ST_RM_WADV:   state_d = status_i.nxt_rd_end ? ST_DONE : ST_RM_W;
      ST_RM_RD:     state_d = ST_RM_LINK;
      ST_RM_LINK:   state_d = ST_RM_CLR;
      ST_RM_CLR:    state_d = ST_DONE;
      ST_FCH_RD: begin
        if (status_i.op == OP_ADD) begin
          state_d = status_i.p_none ? ST_CL_FCH : ST_ADD_START;
        end else begin
          state_d = ST_RFC_TAKE;
        end
      end
      ST_CL_FCH:    state_d = ST_DONE;
      ST_ADD_START: state_d = status_i.fch_rd_none ? ST_DONE : ST_ADD_W;
      ST_ADD_W:     state_d = status_i.cnt_full ? ST_DONE : ST_ADD_SRD;
      ST_ADD_SRD:   state_d = ST_ADD_STEP;
      ST_ADD_STEP:  state_d = status_i.sib_rd_none ? ST_DONE : ST_ADD_W;
      ST_RFC_TAKE:  state_d = status_i.fch_rd_none ? ST_DONE : ST_RFC_SRD;
      ST_RFC_SRD:   state_d = ST_RFC_UNLINK;
      ST_RFC_UNLINK: state_d = ST_DONE;
      ST_PAR_RD:    state_d = ST_DT_UP;
      ST_DT_UP:     state_d = status_i.par_rd_none ? ST_DONE : ST_DT_FCH;
      ST_DT_FCH:    state_d = status_i.fch_rd_eq_p ? ST_DT_HEAD : ST_DT_W;
      ST_DT_HEAD:   state_d = ST_DONE;
      ST_DT_W:      state_d = (status_i.cnt_full || status_i.s_none) ? ST_DONE : ST_DT_SRD;
      ST_DT_SRD:    state_d = ST_DT_STEP;
      ST_DT_STEP:   state_d = status_i.sib_rd_eq_p ? ST_DT_CLR : ST_DT_W;
      ST_DT_CLR:    state_d = ST_DONE;
      ST_DONE:      if (out_load) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[rtl/core/lqpm_dp.sv]
// Datapath of the linked queue pool manager: link memories, tail pointers,
// working registers and the result register. Depends on lqpm_pkg.
module lqpm_dp #(
  parameter int NODES  = 32,
  parameter int QUEUES = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lqpm_pkg::lqpm_cmd_e    cmd_i,
  output lqpm_pkg::lqpm_status_t status_o,
  input  logic [3:0]            opcode_i,
  input  logic [2:0]            queue_sel_i,
  input  logic [4:0]            node_i,
  input  logic [4:0]            parent_node_i,
  output logic [4:0]            node_out_o,
  output logic                  found_o,
  output logic                  queue_empty_o,
  output logic                  childless_o
);
  import lqpm_pkg::*;

  localparam int LW    = $clog2(NODES + 1);
  localparam int IW    = $clog2(NODES);
  localparam int QW    = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int CLR_N = (NODES > QUEUES) ? NODES : QUEUES;
  localparam int CLW   = $clog2(CLR_N);
  localparam logic [LW-1:0] NONE = LW'(NODES);

  logic [LW-1:0] nxt_mem [NODES];
  logic [LW-1:0] prv_mem [NODES];
  logic [LW-1:0] pl_mem  [NODES];
  logic [LW-1:0] fch_mem [NODES];
  logic [LW-1:0] sib_mem [NODES];
  logic [LW-1:0] qt_mem  [QUEUES];

  logic [3:0]     op_q;
  logic [QW-1:0]  qs_q;
  logic           bad_q;
  logic [LW-1:0]  p_q, par_q, t_q, w_q, h_q, n_q, s_q, sp_q, up_q, cnt_q, res_q;
  logic           cl_q;
  logic [LW-1:0]  ft_q;
  logic [CLW-1:0] clr_q;
  logic [LW-1:0]  nxt_rd_q, prv_rd_q, pl_rd_q, fch_rd_q, sib_rd_q, qt_rd_q;
  logic [4:0]     node_out_q;
  logic           found_q, qe_q, cl_out_q;

  logic [LW-1:0] nxt_ra, prv_ra, pl_ra, fch_ra, sib_ra;
  logic          nxt_we, prv_we, pl_we, fch_we, sib_we;
  logic [LW-1:0] nxt_wa, prv_wa, pl_wa, fch_wa, sib_wa;
  logic [LW-1:0] nxt_wd, prv_wd, pl_wd, fch_wd, sib_wd;
  logic          tail_we;
  logic [LW-1:0] tail_wd;
  logic          qt_we;
  logic [QW-1:0] qt_wa;
  logic [LW-1:0] qt_wd;

  logic          is_free, qs_ok, node_ok, par_ok, clr_in_nodes, clr_in_queues;
  logic [LW-1:0] tsrc, node_x, par_x;

  assign is_free       = (op_q <= OP_FREE);
  assign tsrc          = is_free ? ft_q : qt_rd_q;
  assign qs_ok         = 32'(queue_sel_i) < QUEUES;
  assign node_ok       = 32'(node_i) < NODES;
  assign par_ok        = 32'(parent_node_i) < NODES;
  assign node_x        = node_ok ? LW'(node_i) : NONE;
  assign par_x         = par_ok ? LW'(parent_node_i) : NONE;
  assign clr_in_nodes  = 32'(clr_q) < NODES;
  assign clr_in_queues = 32'(clr_q) < QUEUES;

  always_comb begin
    status_o.op          = op_q;
    status_o.bad         = bad_q;
    status_o.p_none      = (p_q >= NONE);
    status_o.par_none    = (par_q >= NONE);
    status_o.t_none      = (t_q >= NONE);
    status_o.tsrc_none   = (tsrc >= NONE);
    status_o.cnt_full    = (cnt_q == NONE);
    status_o.w_eq_p      = (w_q == p_q);
    status_o.s_none      = (s_q >= NONE);
    status_o.nxt_rd_end  = (nxt_rd_q == t_q) || (nxt_rd_q >= NONE);
    status_o.fch_rd_none = (fch_rd_q >= NONE);
    status_o.fch_rd_eq_p = (fch_rd_q == p_q);
    status_o.sib_rd_none = (sib_rd_q >= NONE);
    status_o.sib_rd_eq_p = (sib_rd_q == p_q);
    status_o.par_rd_none = (pl_rd_q >= NONE);
    status_o.clr_done    = (clr_q == CLW'(CLR_N - 1));
  end

  // Read addresses and write ports for the current command.
  always_comb begin
    nxt_ra = NONE; prv_ra = NONE; pl_ra = NONE; fch_ra = NONE; sib_ra = NONE;
    nxt_we = 1'b0; prv_we = 1'b0; pl_we = 1'b0; fch_we = 1'b0; sib_we = 1'b0;
    nxt_wa = NONE; prv_wa = NONE; pl_wa = NONE; fch_wa = NONE; sib_wa = NONE;
    nxt_wd = NONE; prv_wd = NONE; pl_wd = NONE; fch_wd = NONE; sib_wd = NONE;
    tail_we = 1'b0;
    tail_wd = NONE;
    case (cmd_i)
      CMD_CLEAR: begin
        nxt_we = clr_in_nodes; prv_we = clr_in_nodes; pl_we = clr_in_nodes;
        fch_we = clr_in_nodes; sib_we = clr_in_nodes;
        nxt_wa = LW'(clr_q); prv_wa = LW'(clr_q); pl_wa = LW'(clr_q);
        fch_wa = LW'(clr_q); sib_wa = LW'(clr_q);
        nxt_wd = (32'(clr_q) == NODES - 1) ? '0 : LW'(32'(clr_q) + 1);
        prv_wd = (clr_q == '0) ? LW'(NODES - 1) : LW'(32'(clr_q) - 1);
      end
      CMD_RD_NXT_T: nxt_ra = t_q;
      CMD_TAKE_H:   nxt_ra = nxt_rd_q;
      CMD_TAKE_LINK: begin
        if (h_q == t_q) begin
          tail_we = 1'b1;
        end else begin
          prv_we = 1'b1; prv_wa = n_q; prv_wd = t_q;
          nxt_we = 1'b1; nxt_wa = t_q; nxt_wd = n_q;
        end
      end
      CMD_TAKE_CLR: begin
        nxt_we = 1'b1; nxt_wa = h_q;
        prv_we = 1'b1; prv_wa = h_q;
        if (op_q == OP_ALLOC) begin
          pl_we = 1'b1; pl_wa = h_q;
          fch_we = 1'b1; fch_wa = h_q;
          sib_we = 1'b1; sib_wa = h_q;
        end
      end
      CMD_INS_FIRST: begin
        tail_we = 1'b1; tail_wd = p_q;
        nxt_we = 1'b1; nxt_wa = p_q; nxt_wd = p_q;
        prv_we = 1'b1; prv_wa = p_q; prv_wd = p_q;
      end
      CMD_INS_P: begin
        nxt_we = 1'b1; nxt_wa = p_q; nxt_wd = h_q;
        prv_we = 1'b1; prv_wa = p_q; prv_wd = t_q;
      end
      CMD_INS_T: begin
        prv_we = 1'b1; prv_wa = h_q; prv_wd = p_q;
        nxt_we = 1'b1; nxt_wa = t_q; nxt_wd = p_q;
        tail_we = 1'b1; tail_wd = p_q;
      end
      CMD_WALK_RD: nxt_ra = w_q;
      CMD_RM_RD: begin
        nxt_ra = p_q;
        prv_ra = p_q;
      end
      CMD_RM_LINK: begin
        // Removing the tail moves the tail to its successor, or empties a
        // ring of one.
        if (t_q == p_q) begin
          tail_we = 1'b1;
          tail_wd = ((nxt_rd_q == p_q) || (nxt_rd_q >= NONE)) ? NONE : nxt_rd_q;
        end
        prv_we = 1'b1; prv_wa = nxt_rd_q; prv_wd = prv_rd_q;
        nxt_we = 1'b1; nxt_wa = prv_rd_q; nxt_wd = nxt_rd_q;
      end
      CMD_RM_CLR: begin
        nxt_we = 1'b1; nxt_wa = p_q;
        prv_we = 1'b1; prv_wa = p_q;
      end
      CMD_RD_FCH_PAR: fch_ra = par_q;
      CMD_ADD_START: begin
        pl_we = 1'b1; pl_wa = p_q; pl_wd = par_q;
        if (fch_rd_q >= NONE) begin
          fch_we = 1'b1; fch_wa = par_q; fch_wd = p_q;
        end
      end
      CMD_SIB_RD: sib_ra = s_q;
      CMD_ADD_STEP: begin
        if (sib_rd_q >= NONE) begin
          sib_we = 1'b1; sib_wa = s_q; sib_wd = p_q;
        end
      end
      CMD_RFC_UNLINK: begin
        fch_we = 1'b1; fch_wa = par_q; fch_wd = sib_rd_q;
        pl_we = 1'b1; pl_wa = s_q;
        sib_we = 1'b1; sib_wa = s_q;
      end
      CMD_RD_PARENT: pl_ra = p_q;
      CMD_DT_UP: begin
        fch_ra = pl_rd_q;
        sib_ra = p_q;
      end
      CMD_DT_HEAD: begin
        fch_we = 1'b1; fch_wa = up_q; fch_wd = sp_q;
        pl_we = 1'b1; pl_wa = p_q;
        sib_we = 1'b1; sib_wa = p_q;
      end
      CMD_DT_STEP: begin
        if (sib_rd_q == p_q) begin
          sib_we = 1'b1; sib_wa = s_q; sib_wd = sp_q;
        end
      end
      CMD_DT_CLR: begin
        pl_we = 1'b1; pl_wa = p_q;
        sib_we = 1'b1; sib_wa = p_q;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (cmd_i == CMD_CLEAR) begin
      qt_we = clr_in_queues;
      qt_wa = QW'(clr_q);
      qt_wd = NONE;
    end else begin
      qt_we = tail_we && !is_free;
      qt_wa = qs_q;
      qt_wd = tail_wd;
    end
  end

  // Link memories: one write and one registered read each per cycle.
  always_ff @(posedge clk_i) begin
    if (nxt_we && (nxt_wa < NONE)) nxt_mem[nxt_wa[IW-1:0]] <= nxt_wd;
    nxt_rd_q <= (nxt_ra < NONE) ? nxt_mem[nxt_ra[IW-1:0]] : NONE;
  end

  always_ff @(posedge clk_i) begin
    if (prv_we && (prv_wa < NONE)) prv_mem[prv_wa[IW-1:0]] <= prv_wd;
    prv_rd_q <= (prv_ra < NONE) ? prv_mem[prv_ra[IW-1:0]] : NONE;
  end

  always_ff @(posedge clk_i) begin
    if (pl_we && (pl_wa < NONE)) pl_mem[pl_wa[IW-1:0]] <= pl_wd;
    pl_rd_q <= (pl_ra < NONE) ? pl_mem[pl_ra[IW-1:0]] : NONE;
  end

  always_ff @(posedge clk_i) begin
    if (fch_we && (fch_wa < NONE)) fch_mem[fch_wa[IW-1:0]] <= fch_wd;
    fch_rd_q <= (fch_ra < NONE) ? fch_mem[fch_ra[IW-1:0]] : NONE;
  end

  always_ff @(posedge clk_i) begin
    if (sib_we && (sib_wa < NONE)) sib_mem[sib_wa[IW-1:0]] <= sib_wd;
    sib_rd_q <= (sib_ra < NONE) ? sib_mem[sib_ra[IW-1:0]] : NONE;
  end

  always_ff @(posedge clk_i) begin
    if (qt_we) qt_mem[qt_wa] <= qt_wd;
    qt_rd_q <= qt_mem[qs_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ft_q  <= LW'(NODES - 1);
      clr_q <= '0;
    end else begin
      if (cmd_i == CMD_CLEAR) clr_q <= clr_q + 1'b1;
      if (tail_we && is_free) ft_q <= tail_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_CAPTURE: begin
        op_q  <= opcode_i;
        qs_q  <= QW'(queue_sel_i);
        bad_q <= (opcode_i > OP_DETACH) ||
                 ((opcode_i >= OP_ENQUEUE) && (opcode_i <= OP_PEEK) && !qs_ok);
        p_q   <= node_x;
        par_q <= par_x;
        res_q <= NONE;
        cl_q  <= 1'b0;
        cnt_q <= '0;
      end
      CMD_LD_TAIL: begin
        t_q <= tsrc;
        w_q <= tsrc;
      end
      CMD_TAKE_H:    h_q <= nxt_rd_q;
      CMD_TAKE_N:    n_q <= nxt_rd_q;
      CMD_TAKE_CLR:  res_q <= h_q;
      CMD_PEEK:      res_q <= nxt_rd_q;
      CMD_WALK_ADV: begin
        w_q   <= nxt_rd_q;
        cnt_q <= cnt_q + 1'b1;
      end
      CMD_RM_CLR:    res_q <= p_q;
      CMD_CL_FCH:    cl_q <= (fch_rd_q >= NONE);
      CMD_ADD_START: s_q <= fch_rd_q;
      CMD_ADD_STEP: begin
        if (sib_rd_q < NONE) begin
          s_q   <= sib_rd_q;
          cnt_q <= cnt_q + 1'b1;
        end
      end
      CMD_RFC_TAKE: begin
        s_q  <= fch_rd_q;
        cl_q <= (fch_rd_q >= NONE);
      end
      CMD_RFC_UNLINK: begin
        res_q <= s_q;
        cl_q  <= (sib_rd_q >= NONE);
      end
      CMD_DT_UP:     up_q <= pl_rd_q;
      CMD_DT_FCH: begin
        s_q  <= fch_rd_q;
        sp_q <= sib_rd_q;
        cl_q <= (fch_rd_q >= NONE);
      end
      CMD_DT_HEAD: begin
        res_q <= p_q;
        cl_q  <= (sp_q >= NONE);
      end
      CMD_DT_STEP: begin
        if (sib_rd_q != p_q) begin
          s_q   <= sib_rd_q;
          cnt_q <= cnt_q + 1'b1;
        end
      end
      CMD_DT_CLR:    res_q <= p_q;
      CMD_OUT: begin
        found_q    <= (res_q < NONE);
        node_out_q <= (res_q < NONE) ? 5'(res_q) : 5'd0;
        qe_q       <= (op_q <= OP_PEEK) && !bad_q && (t_q >= NONE);
        cl_out_q   <= cl_q;
      end
      default: begin
      end
    endcase
    if (tail_we) t_q <= tail_wd;
  end

  assign node_out_o    = node_out_q;
  assign found_o       = found_q;
  assign queue_empty_o = qe_q;
  assign childless_o   = cl_out_q;

endmodule

[rtl/core/linked_queue_pool_manager.sv]
// Top level of the linked queue pool manager.
// Instantiates lqpm_ctrl and lqpm_dp; depends on lqpm_pkg.
//
// Usage: one request channel (in_valid_i / in_stall_o with opcode, queue,
// node and parent fields) and one result channel (out_valid_o / out_stall_i
// with node_out, found, queue_empty and childless). Every request gives
// exactly one result, in request order.
// Remove named, add child and detach child walk a chain, one link per pass
// through a wait, a read and a step state. The walks run on the single read
// port of each link memory, so one request is in flight at a time; the next
// request is taken the cycle after the previous result is registered.
// After reset the block runs a clearing pass that rebuilds the free ring and
// empties all queues and child links; in_stall_o is high during the pass.
// The result sits in an output register; a request can be accepted while
// that result waits. If the receiver stalls, a finished result waits in the
// controller until the output register is free again.
module linked_queue_pool_manager #(
  parameter int NODES  = 32,
  parameter int QUEUES = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [3:0] opcode_i,
  input  logic [2:0] queue_sel_i,
  input  logic [4:0] node_i,
  input  logic [4:0] parent_node_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [4:0] node_out_o,
  output logic       found_o,
  output logic       queue_empty_o,
  output logic       childless_o
);
  import lqpm_pkg::*;

  // Command from the controller and status back from the datapath.
  lqpm_cmd_e    cmd;
  lqpm_status_t status;

  lqpm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lqpm_dp #(
    .NODES  (NODES),
    .QUEUES (QUEUES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .opcode_i      (opcode_i),
    .queue_sel_i   (queue_sel_i),
    .node_i        (node_i),
    .parent_node_i (parent_node_i),
    .node_out_o    (node_out_o),
    .found_o       (found_o),
    .queue_empty_o (queue_empty_o),
    .childless_o   (childless_o)
  );

endmodule

[rtl/core/lqpm_checker.sv]
// Port checker of the linked queue pool manager, bound to the top level.
// Depends only on the top level's ports.
module lqpm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [3:0] opcode_i,
  input logic [2:0] queue_sel_i,
  input logic [4:0] node_i,
  input logic [4:0] parent_node_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [4:0] node_out_o,
  input logic       found_o,
  input logic       queue_empty_o,
  input logic       childless_o
);

  // A request is worked on alone: stall rises right after acceptance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted while another is in flight");

  // A new result appears only as the block returns to accepting requests.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("result presented without returning to idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      ($stable(node_out_o) && $stable(found_o) &&
       $stable(queue_empty_o) && $stable(childless_o)))
    else $error("result changed while stalled");

endmodule

bind linked_queue_pool_manager lqpm_checker u_lqpm_checker (.*);
